@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bitmap block allocator.
// Used by bba_scan_unit, bba_map_mem and bitmap_block_allocator_core; no dependencies.

package bba_pkg;

    // Free-map storage word; one bit per block, 1 means free.
    localparam int WORD_W = 32;
    localparam int POS_W  = $clog2(WORD_W);

    // Configuration register width and port index width.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Field widths of the request and response beats.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    localparam int MAX_BLOCKS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_COUNT_RST = 13'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_UPDATE,
        S_INIT,
        S_REPLY
    } state_t;

    // Result of evaluating one map word against the configured limits.
    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos;
        logic              more;
        logic [WORD_W-1:0] eff_mask;
        logic [WORD_W-1:0] rsv_mask;
    } scan_res_t;

endpackage

@@ hw/rtl/bba_scan_unit.sv @@
`timescale 1ns / 1ps
// Word evaluation unit: limit masks and first-free search over one map word.
// Depends on bba_pkg.

module bba_scan_unit #(
    parameter int CMP_W = 13
) (
    input  logic [CMP_W-1:0]           base,
    input  logic [CMP_W-1:0]           eff,
    input  logic [CMP_W-1:0]           rsv,
    input  logic [bba_pkg::WORD_W-1:0] word,
    output bba_pkg::scan_res_t         res
);
    import bba_pkg::*;

    logic [CMP_W-1:0]  diff_eff;
    logic [CMP_W-1:0]  diff_rsv;
    logic [WORD_W-1:0] masked;

    assign diff_eff = eff - base;
    assign diff_rsv = rsv - base;

    always_comb
    begin
        res = '0;

        // Bits of this word whose block index lies below the block count.
        if (eff <= base)
        begin
            res.eff_mask = '0;
        end
        else if (diff_eff >= CMP_W'(WORD_W))
        begin
            res.eff_mask = '1;
        end
        else
        begin
            res.eff_mask = ~({WORD_W{1'b1}} << diff_eff[POS_W-1:0]);
        end

        // Bits of this word whose block index lies below the reserved count.
        if (rsv <= base)
        begin
            res.rsv_mask = '0;
        end
        else if (diff_rsv >= CMP_W'(WORD_W))
        begin
            res.rsv_mask = '1;
        end
        else
        begin
            res.rsv_mask = ~({WORD_W{1'b1}} << diff_rsv[POS_W-1:0]);
        end

        // Managed blocks continue past the end of this word.
        res.more = (eff > base) && (diff_eff > CMP_W'(WORD_W));

        masked    = word & res.eff_mask;
        res.found = |masked;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                res.pos = POS_W'(i);
            end
        end
    end

endmodule

@@ hw/rtl/bba_map_mem.sv @@
`timescale 1ns / 1ps
// Free-map storage: one write port and one registered read port.
// Depends on bba_pkg for the word width.

module bba_map_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bba_pkg::WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bba_pkg::WORD_W-1:0] rd_data
);
    import bba_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bitmap_block_allocator_core.sv @@
`timescale 1ns / 1ps
// First-fit bitmap block allocator: sequencer, configuration and response register.
// Depends on bba_pkg, bba_scan_unit and bba_map_mem.
//
// Usage:
//   A request beat carries an operation and a block index; each request yields
//   exactly one response beat with a status and the granted index.
//   Configuration writes (block count, reserved count) go through the plain
//   write port and must be issued only while the block is idle.
//   The free map is held in 32-bit words in a memory with one write port and one
//   registered read port; one word is handled per cycle and the word unit evaluates it.
//   Steps from request to response:
//     allocate         scan map words from word 0 up to the first free block, at most
//                      the words that hold the managed blocks; no scan if the count is zero
//     release / mark   an update of the indexed word, skipped when the index is out of range
//     initialize       write every map word with the free range
//   One request is in flight at a time; in_stall is high until its response is
//   loaded into the output register, and the next request may be taken while
//   that response waits.
//   Reset: after rst_n deasserts, a clearing pass writes every map word as used,
//   with in_stall high. While out_stall is high a finished response stays in the
//   output register and the sequencer waits before loading the next one.

module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bba_pkg::OP_W-1:0]      operation,
    input  logic [bba_pkg::INDEX_W-1:0]   block_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    output logic [bba_pkg::INDEX_W-1:0]   allocated_index,
    input  logic                          cfg_write,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);
    import bba_pkg::*;

    localparam int DEPTH  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BASE_W = ADDR_W + POS_W;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_A  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W  = (CMP_A > BASE_W) ? CMP_A : BASE_W;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(DEPTH - 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  word_reg, word_next;
    logic [POS_W-1:0]   bitpos_reg, bitpos_next;
    op_t                op_reg, op_next;
    status_t            stat_reg, stat_next;
    logic [INDEX_W-1:0] grant_reg, grant_next;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic [CFG_W-1:0]   block_count_reg;
    logic [CFG_W-1:0]   reserved_count_reg;

    logic [CMP_W-1:0]   block_cmp;
    logic [CMP_W-1:0]   max_cmp;
    logic [CMP_W-1:0]   eff;
    logic [CMP_W-1:0]   rsv;
    logic [CMP_W-1:0]   base;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   grant_ext;
    logic               idx_range_err;
    logic               out_free;
    logic               load_out;
    op_t                in_op;

    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0]  bit_sel;
    scan_res_t          scan;

    // Configuration and derived limits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg    <= BLOCK_COUNT_RST;
            reserved_count_reg <= RESERVED_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_COUNT:    block_count_reg    <= cfg_data;
                CFG_RESERVED_COUNT: reserved_count_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign block_cmp = CMP_W'(block_count_reg);
    assign max_cmp   = CMP_W'(MAX_BLOCKS);
    assign eff       = (block_cmp < max_cmp) ? block_cmp : max_cmp;
    assign rsv       = CMP_W'(reserved_count_reg);
    assign base      = CMP_W'({word_reg, {POS_W{1'b0}}});
    assign grant_ext = CMP_W'({word_reg, scan.pos});

    assign idx_ext       = CMP_W'(block_index);
    assign idx_range_err = (idx_ext >= eff);
    assign in_op         = op_t'(operation);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign bit_sel  = WORD_W'(1) << bitpos_reg;

    bba_scan_unit #(
        .CMP_W (CMP_W)
    ) u_scan (
        .base (base),
        .eff  (eff),
        .rsv  (rsv),
        .word (rd_data),
        .res  (scan)
    );

    // The read address follows the next word pointer, so the registered read
    // data holds the word that word_reg points at (its old contents just after a write to it).
    bba_map_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_data),
        .rd_addr (word_next),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_ALLOC:   state_next = (eff == '0) ? S_REPLY : S_ALLOC;
                        OP_RELEASE: state_next = idx_range_err ? S_REPLY : S_UPDATE;
                        OP_MARK:    state_next = idx_range_err ? S_REPLY : S_UPDATE;
                        OP_INIT:    state_next = S_INIT;
                        default:    state_next = S_REPLY;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (scan.found || !scan.more)
                begin
                    state_next = S_REPLY;
                end
            end
            S_UPDATE:
            begin
                state_next = S_REPLY;
            end
            S_INIT:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls and register next values.
    always_comb
    begin
        word_next   = word_reg;
        bitpos_next = bitpos_reg;
        op_next     = op_reg;
        stat_next   = stat_reg;
        grant_next  = grant_reg;
        wr_en       = 1'b0;
        wr_data     = '0;
        load_out    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                word_next = word_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    grant_next = '0;
                    case (in_op)
                        OP_ALLOC:
                        begin
                            word_next = '0;
                            stat_next = ST_FULL;
                        end
                        OP_RELEASE, OP_MARK:
                        begin
                            word_next   = idx_ext[BASE_W-1:POS_W];
                            bitpos_next = idx_ext[POS_W-1:0];
                            stat_next   = idx_range_err ? ST_RANGE : ST_OK;
                        end
                        default:
                        begin
                            word_next = '0;
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (scan.found)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data & ~(WORD_W'(1) << scan.pos);
                    stat_next  = ST_OK;
                    grant_next = grant_ext[INDEX_W-1:0];
                end
                else if (scan.more)
                begin
                    word_next = word_reg + ADDR_W'(1);
                end
            end
            S_UPDATE:
            begin
                wr_en   = 1'b1;
                wr_data = (op_reg == OP_RELEASE) ? (rd_data | bit_sel)
                                                 : (rd_data & ~bit_sel);
            end
            S_INIT:
            begin
                // Free exactly the blocks between the reserved and block counts.
                wr_en     = 1'b1;
                wr_data   = scan.eff_mask & ~scan.rsv_mask;
                word_next = word_reg + ADDR_W'(1);
            end
            S_REPLY:
            begin
                load_out = out_free;
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bitpos_reg <= bitpos_next;
        op_reg     <= op_next;
        stat_reg   <= stat_next;
        grant_reg  <= grant_next;
    end

    // Response register: holds a finished beat while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= stat_reg;
            out_index_reg  <= grant_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign allocated_index = out_index_reg;

endmodule
